@@ hw/rtl/qtks_pkg.sv @@
`timescale 1ns / 1ps

package qtks_pkg;

   // Default sizing of the ranking list and the class stream
   localparam int TOP_COUNT_DEF   = 5;
   localparam int MAX_CLASSES_DEF = 2048;

   // Fixed field widths
   localparam int RAW_W   = 8;
   localparam int ZP_W    = 9;
   localparam int SCORE_W = 10;
   localparam int RANK_W  = 3;
   localparam int CLASS_W = 11;

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCORE_FORMAT = 1'b0,
      CSR_ZERO_POINT   = 1'b1
   } csr_index_type;

   typedef logic signed [SCORE_W-1:0] score_type;
   typedef logic signed [ZP_W-1:0]    zp_offset_type;

endpackage

@@ hw/rtl/qtks_if.sv @@
`timescale 1ns / 1ps

// Score stream: one raw byte per class, in class order
interface qtks_req_if;
   logic                          valid;
   logic                          ready;
   logic [qtks_pkg::RAW_W-1:0]    raw_score;
   logic                          final_class;

   modport source (output valid, raw_score, final_class, input ready);
   modport sink   (input valid, raw_score, final_class, output ready);
endinterface

// Ranked results, best first
interface qtks_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [qtks_pkg::RANK_W-1:0]   rank;
   logic [qtks_pkg::CLASS_W-1:0]  class_index;
   logic signed [qtks_pkg::SCORE_W-1:0] centred_score;
   logic                          last_rank;

   modport source (output valid, rank, class_index, centred_score, last_rank, input ready);
   modport sink   (input valid, rank, class_index, centred_score, last_rank, output ready);
endinterface

// Register write channel
interface qtks_csr_if;
   logic                           valid;
   logic                           ready;
   logic [qtks_pkg::CSR_IDX_W-1:0]  index;
   logic [qtks_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/qtks_insert.sv @@
`timescale 1ns / 1ps

module qtks_insert #(
   parameter int TOP_COUNT   = qtks_pkg::TOP_COUNT_DEF,
   parameter int MAX_CLASSES = qtks_pkg::MAX_CLASSES_DEF,
   localparam int IDX_W  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1,
   localparam int CNT_W  = $clog2(MAX_CLASSES + 1),
   localparam int FILL_W = $clog2(TOP_COUNT + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   qtks_req_if.sink                  req,
   input  logic                      score_format,
   input  qtks_pkg::zp_offset_type   zp_offset,
   input  logic                      drain_free,
   output logic                      snap_load,
   output logic [FILL_W-1:0]         snap_fill,
   output logic [IDX_W-1:0]          snap_idx   [TOP_COUNT],
   output qtks_pkg::score_type       snap_score [TOP_COUNT]
);

   // Input register
   logic                     s1_valid_ff, s1_valid_in;
   logic                     s1_final_ff;
   qtks_pkg::score_type      s1_score_ff;
   logic                     advance;
   logic                     req_xfer;
   logic signed [qtks_pkg::ZP_W-1:0] raw_val;
   qtks_pkg::score_type      centred;

   // Ranking list
   logic [IDX_W-1:0]         idx_ff   [TOP_COUNT];
   qtks_pkg::score_type      score_ff [TOP_COUNT];
   logic [FILL_W-1:0]        fill_ff;
   logic [CNT_W-1:0]         cnt_ff;

   logic [IDX_W-1:0]         idx_new   [TOP_COUNT];
   qtks_pkg::score_type      score_new [TOP_COUNT];
   logic [FILL_W-1:0]        fill_new;
   logic [TOP_COUNT-1:0]     keep;
   logic                     take;
   logic                     sorted_ok;

   // Accept while the input register is empty or moves on this cycle
   assign advance   = s1_valid_ff && (!s1_final_ff || drain_free);
   assign req.ready = !s1_valid_ff || advance;
   assign req_xfer  = req.valid && req.ready;
   assign s1_valid_in = req_xfer || (s1_valid_ff && !advance);

   // Center the raw byte on the zero point
   always_comb begin
      if (score_format) begin
         raw_val = {req.raw_score[qtks_pkg::RAW_W-1], req.raw_score};
      end else begin
         raw_val = {1'b0, req.raw_score};
      end
      centred = qtks_pkg::score_type'(raw_val) - qtks_pkg::score_type'(zp_offset);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_xfer) begin
         s1_score_ff <= centred;
         s1_final_ff <= req.final_class;
      end
   end

   // Compare against every slot at once; an equal score keeps its place
   assign take = cnt_ff < CNT_W'(MAX_CLASSES);

   always_comb begin
      for (int j = 0; j < TOP_COUNT; j++) begin
         keep[j] = (FILL_W'(j) < fill_ff) && (score_ff[j] >= s1_score_ff);
      end
      for (int j = 0; j < TOP_COUNT; j++) begin
         if (!take || keep[j]) begin
            idx_new[j]   = idx_ff[j];
            score_new[j] = score_ff[j];
         end else if (j == 0 || keep[(j > 0) ? j - 1 : 0]) begin
            idx_new[j]   = cnt_ff[IDX_W-1:0];
            score_new[j] = s1_score_ff;
         end else begin
            idx_new[j]   = idx_ff[(j > 0) ? j - 1 : 0];
            score_new[j] = score_ff[(j > 0) ? j - 1 : 0];
         end
      end
      if (take && !keep[TOP_COUNT-1] && fill_ff < FILL_W'(TOP_COUNT)) begin
         fill_new = fill_ff + 1'b1;
      end else begin
         fill_new = fill_ff;
      end
   end

   // Hand the finished list to the drain side
   assign snap_load  = advance && s1_final_ff;
   assign snap_fill  = fill_new;
   assign snap_idx   = idx_new;
   assign snap_score = score_new;

   // Advance the list; clear it when a run ends
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         cnt_ff  <= '0;
      end else if (advance) begin
         if (s1_final_ff) begin
            fill_ff <= '0;
            cnt_ff  <= '0;
         end else begin
            fill_ff <= fill_new;
            if (take) begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && !s1_final_ff) begin
         idx_ff   <= idx_new;
         score_ff <= score_new;
      end
   end

   always_comb begin
      sorted_ok = 1'b1;
      for (int j = 1; j < TOP_COUNT; j++) begin
         if (FILL_W'(j) < fill_ff && score_ff[j] > score_ff[j-1]) begin
            sorted_ok = 1'b0;
         end
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(TOP_COUNT))
      else $error("ranking list overfilled");

   a_sorted: assert property (@(posedge clock) disable iff (reset)
      sorted_ok)
      else $error("ranking list out of order");

   a_fill_vs_count: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(fill_ff) <= cnt_ff)
      else $error("more entries than classes seen");

   a_final_waits: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_final_ff && !drain_free) |=> s1_valid_ff)
      else $error("final score dropped while results drain");

endmodule

@@ hw/rtl/qtks_drain.sv @@
`timescale 1ns / 1ps

module qtks_drain #(
   parameter int TOP_COUNT   = qtks_pkg::TOP_COUNT_DEF,
   parameter int MAX_CLASSES = qtks_pkg::MAX_CLASSES_DEF,
   localparam int IDX_W  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1,
   localparam int FILL_W = $clog2(TOP_COUNT + 1),
   localparam int SLOT_W = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  snap_load,
   input  logic [FILL_W-1:0]     snap_fill,
   input  logic [IDX_W-1:0]      snap_idx   [TOP_COUNT],
   input  qtks_pkg::score_type   snap_score [TOP_COUNT],
   output logic                  drain_free,
   qtks_rsp_if.source            rsp
);

   localparam int RankW  = qtks_pkg::RANK_W;
   localparam int ClassW = qtks_pkg::CLASS_W;

   logic [IDX_W-1:0]        idx_ff   [TOP_COUNT];
   qtks_pkg::score_type     score_ff [TOP_COUNT];
   logic [FILL_W-1:0]       fill_ff;
   logic [FILL_W-1:0]       ptr_ff;
   logic [FILL_W-1:0]       ptr_next;
   logic                    rsp_xfer;
   logic                    last;

   // Walk the held list one result per transfer
   assign ptr_next = ptr_ff + 1'b1;
   assign last     = ptr_next == fill_ff;
   assign rsp.valid = ptr_ff < fill_ff;
   assign rsp_xfer  = rsp.valid && rsp.ready;
   assign drain_free = !rsp.valid || (rsp_xfer && last);

   assign rsp.rank          = RankW'(ptr_ff);
   assign rsp.class_index   = ClassW'(idx_ff[ptr_ff[SLOT_W-1:0]]);
   assign rsp.centred_score = score_ff[ptr_ff[SLOT_W-1:0]];
   assign rsp.last_rank     = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         ptr_ff  <= '0;
      end else if (snap_load) begin
         fill_ff <= snap_fill;
         ptr_ff  <= '0;
      end else if (rsp_xfer) begin
         ptr_ff <= ptr_next;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_load) begin
         idx_ff   <= snap_idx;
         score_ff <= snap_score;
      end
   end

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      snap_load |-> drain_free)
      else $error("result list overwritten before drained");

   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= fill_ff)
      else $error("result pointer past list");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && last && !snap_load) |=> !rsp.valid)
      else $error("results continue after last rank");

endmodule

@@ hw/rtl/quantized_top_k_class_select.sv @@
`timescale 1ns / 1ps

// Top-k class selection over a stream of quantized classifier scores.
// Send one raw score byte per class, in class order, and mark the last one
// with final_class. Each byte is read as uint8 or int8 (score_format) and
// centred by subtracting the zero point register; the TOP_COUNT best classes
// are kept sorted, the lower class index winning a tie. Scores beyond
// MAX_CLASSES in a run are ignored. After the final score the list comes out
// best first, one result per cycle while ready is high, with last_rank on
// the final one; a run with fewer scores than TOP_COUNT yields only that many
// results. The block takes one score per cycle unless a final score waits:
// an input register feeds a single compare-and-shift step over all list
// slots in parallel. The list moves to the drain registers as the final
// score leaves. The next run's scores are taken while results drain; its
// final score waits in the input register until the previous run's last
// result has been transferred. Write registers only while the block is idle.
module quantized_top_k_class_select #(
   parameter int TOP_COUNT   = qtks_pkg::TOP_COUNT_DEF,
   parameter int MAX_CLASSES = qtks_pkg::MAX_CLASSES_DEF
) (
   input  logic          clock,
   input  logic          reset,
   qtks_req_if.sink      req_chan,
   qtks_rsp_if.source    rsp_chan,
   qtks_csr_if.sink      csr_chan
);

   localparam int IDX_W  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
   localparam int FILL_W = $clog2(TOP_COUNT + 1);

   logic                      fmt_ff;
   qtks_pkg::zp_offset_type   zp_ff;
   logic                      csr_xfer;

   logic                      drain_free;
   logic                      snap_load;
   logic [FILL_W-1:0]         snap_fill;
   logic [IDX_W-1:0]          snap_idx   [TOP_COUNT];
   qtks_pkg::score_type       snap_score [TOP_COUNT];

   // Configuration registers
   assign csr_chan.ready = 1'b1;
   assign csr_xfer = csr_chan.valid && csr_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= 1'b0;
         zp_ff  <= '0;
      end else if (csr_xfer) begin
         unique case (qtks_pkg::csr_index_type'(csr_chan.index))
            qtks_pkg::CSR_SCORE_FORMAT: fmt_ff <= csr_chan.data[0];
            qtks_pkg::CSR_ZERO_POINT:   zp_ff  <= csr_chan.data;
            default: ;
         endcase
      end
   end

   qtks_insert #(
      .TOP_COUNT   (TOP_COUNT),
      .MAX_CLASSES (MAX_CLASSES)
   ) u_insert (
      .clock        (clock),
      .reset        (reset),
      .req          (req_chan),
      .score_format (fmt_ff),
      .zp_offset    (zp_ff),
      .drain_free   (drain_free),
      .snap_load    (snap_load),
      .snap_fill    (snap_fill),
      .snap_idx     (snap_idx),
      .snap_score   (snap_score)
   );

   qtks_drain #(
      .TOP_COUNT   (TOP_COUNT),
      .MAX_CLASSES (MAX_CLASSES)
   ) u_drain (
      .clock      (clock),
      .reset      (reset),
      .snap_load  (snap_load),
      .snap_fill  (snap_fill),
      .snap_idx   (snap_idx),
      .snap_score (snap_score),
      .drain_free (drain_free),
      .rsp        (rsp_chan)
   );

endmodule
